// ===== rtl/mfbtb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfbtb_pkg
// Shared types and constants for the monochrome framebuffer text blitter.
// ----------------------------------------------------------------------------
package mfbtb_pkg;

	localparam int SCREEN_WIDTH_DEF   = 128;
	localparam int SCREEN_HEIGHT_DEF  = 64;
	localparam int GLYPH_COUNT_DEF    = 96;
	localparam int MAX_GLYPH_ROWS_DEF = 18;

	localparam int CMD_W       = 3;
	localparam int COORD_W     = 8;
	localparam int CODE_W      = 8;
	localparam int GIDX_IN_W   = 11;
	localparam int GBITS_W     = 16;
	localparam int ADDR_IN_W   = 10;
	localparam int STATUS_W    = 2;
	localparam int BYTE_W      = 8;
	localparam int FONT_W      = 5;
	localparam int CFG_INDEX_W = 1;
	localparam int GIDX_W      = 13;
	localparam int S_TDATA_W   = 64;
	localparam int M_TDATA_W   = 16;

	localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;
	localparam int                FIRST_CODE_INT = 32;
	localparam logic [BYTE_W-1:0] FILL_BLACK = 8'h00;
	localparam logic [BYTE_W-1:0] FILL_WHITE = 8'hFF;
	localparam logic [FONT_W-1:0] FONT_WIDTH_RST  = 5'd7;
	localparam logic [FONT_W-1:0] FONT_HEIGHT_RST = 5'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILL       = 3'd0,
		CMD_PIXEL      = 3'd1,
		CMD_CHAR       = 3'd2,
		CMD_CURSOR     = 3'd3,
		CMD_INVERT     = 3'd4,
		CMD_LOAD_GLYPH = 3'd5,
		CMD_READ_BYTE  = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_CODE  = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FONT_WIDTH  = 1'b0,
		REG_FONT_HEIGHT = 1'b1
	} reg_index_t;

endpackage

// ===== rtl/mono_framebuffer_text_blitter_core.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_text_blitter_core
// Page-layout monochrome framebuffer with pixel, fill, read and glyph blit.
//
// channel  | dir | handshake         | payload
// s_       | in  | s_tvalid/s_tready | s_tuser command, s_tdata arguments
// m_       | out | m_tvalid/m_tready | m_tuser status, m_tdata char and byte
// cfg_     | in  | cfg_we            | cfg_index register, cfg_data value
//
// cursor, invert, glyph load and refused commands finish in the idle state that
// takes them; read byte and pixel read frame memory first, pixel then writes back.
// fill writes one frame byte per cycle; a character reads then writes the frame
// port for each pixel, row by row over font_width * font_height pixels.
// after reset a clearing pass writes every frame byte, one per cycle, and
// no item is taken meanwhile.
// a held result stalls the last step of a command until the output frees.
// ----------------------------------------------------------------------------
module mono_framebuffer_text_blitter_core
	import mfbtb_pkg::*;
#(
	parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT  = SCREEN_HEIGHT_DEF,
	parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
	parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// pos_x, pos_y, colour, char_code, glyph_row_index, glyph_row_bits,
	// byte_address, zero pad
	input  logic [S_TDATA_W-1:0]   s_tdata,
	// command
	input  logic [CMD_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// returned_char, read_byte
	output logic [M_TDATA_W-1:0]   m_tdata,
	// status
	output logic [STATUS_W-1:0]    m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [FONT_W-1:0]      cfg_data
);

	localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
	localparam int FRAME_BYTES = SCREEN_WIDTH * PAGES;
	localparam int FA_W        = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int GLYPH_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
	localparam int GA_W        = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
	localparam logic [FA_W-1:0] FA_LAST = FA_W'(FRAME_BYTES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_PIX_WR,
		ST_RD,
		ST_CH_RD,
		ST_CH_WR
	} state_t;

	function automatic logic [FA_W-1:0] fb_addr(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		fb_addr = FA_W'(int'(x) + int'(y[COORD_W-1:3]) * SCREEN_WIDTH);
	endfunction

	state_t                state_q;
	logic [FA_W-1:0]       fill_cnt_q;
	logic [BYTE_W-1:0]     fill_val_q;
	logic [FONT_W-1:0]     font_width_q;
	logic [FONT_W-1:0]     font_height_q;
	logic [COORD_W-1:0]    cursor_col_q;
	logic [COORD_W-1:0]    cursor_row_q;
	logic                  invert_q;
	logic [FA_W-1:0]       addr_q;
	logic [2:0]            bitsel_q;
	logic                  colour_q;
	logic [CODE_W-1:0]     code_q;
	logic [GIDX_W-1:0]     gidx_q;
	logic [FONT_W-1:0]     col_q;
	logic [FONT_W-1:0]     row_q;
	logic                  gly_ok_q;
	logic                  m_valid_q;
	logic [STATUS_W-1:0]   m_status_q;
	logic [CODE_W-1:0]     m_char_q;
	logic [BYTE_W-1:0]     m_byte_q;

	logic [BYTE_W-1:0]     fb_mem [FRAME_BYTES];
	logic [BYTE_W-1:0]     fb_rdata_q;
	logic [GBITS_W-1:0]    gly_mem [GLYPH_DEPTH];
	logic [GBITS_W-1:0]    gly_rdata_q;

	logic                  fb_re;
	logic [FA_W-1:0]       fb_raddr;
	logic                  fb_we;
	logic [FA_W-1:0]       fb_waddr;
	logic [BYTE_W-1:0]     fb_wdata;
	logic                  gly_re;
	logic                  gly_we;

	logic [COORD_W-1:0]    in_pos_x;
	logic [COORD_W-1:0]    in_pos_y;
	logic                  in_colour;
	logic [CODE_W-1:0]     in_char;
	logic [GIDX_IN_W-1:0]  in_gidx;
	logic [GBITS_W-1:0]    in_gbits;
	logic [ADDR_IN_W-1:0]  in_addr;
	cmd_t                  in_cmd;

	logic                  out_free;
	logic                  accept;
	logic                  pix_on_screen;
	logic                  char_edge_bad;
	logic                  char_code_bad;
	logic                  char_empty;
	logic                  in_addr_ok;
	logic                  in_gidx_ok;
	logic [GIDX_W-1:0]     gidx_base;
	logic [COORD_W-1:0]    ch_x;
	logic [COORD_W-1:0]    ch_y;
	logic [GBITS_W-1:0]    glyph_bits;
	logic                  glyph_on;
	logic                  wr_bit;
	logic [BYTE_W-1:0]     wr_mask;
	logic                  last_col;
	logic                  last_row;

	assign in_pos_x  = s_tdata[7:0];
	assign in_pos_y  = s_tdata[15:8];
	assign in_colour = s_tdata[16];
	assign in_char   = s_tdata[24:17];
	assign in_gidx   = s_tdata[35:25];
	assign in_gbits  = s_tdata[51:36];
	assign in_addr   = s_tdata[61:52];
	assign in_cmd    = cmd_t'(s_tuser);

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_byte_q, m_char_q};
	assign m_tuser  = m_status_q;

	assign pix_on_screen = (int'(in_pos_x) < SCREEN_WIDTH) && (int'(in_pos_y) < SCREEN_HEIGHT);
	assign char_edge_bad = (int'(cursor_col_q) + int'(font_width_q) > SCREEN_WIDTH)
		|| (int'(cursor_row_q) + int'(font_height_q) > SCREEN_HEIGHT);
	assign char_code_bad = (in_char < FIRST_CODE)
		|| (int'(in_char) >= FIRST_CODE_INT + GLYPH_COUNT);
	assign char_empty    = (font_width_q == '0) || (font_height_q == '0);
	assign in_addr_ok    = int'(in_addr) < FRAME_BYTES;
	assign in_gidx_ok    = int'(in_gidx) < GLYPH_DEPTH;
	assign gidx_base     = GIDX_W'(GIDX_W'(in_char - FIRST_CODE) * GIDX_W'(font_height_q));

	assign ch_x       = cursor_col_q + COORD_W'(col_q);
	assign ch_y       = cursor_row_q + COORD_W'(row_q);
	assign glyph_bits = gly_ok_q ? gly_rdata_q : '0;
	assign glyph_on   = (col_q < 5'd16) && glyph_bits[4'd15 - col_q[3:0]];
	assign last_col   = col_q == (font_width_q - 5'd1);
	assign last_row   = row_q == (font_height_q - 5'd1);
	assign wr_bit     = (state_q == ST_CH_WR) ? ((glyph_on ? colour_q : !colour_q) ^ invert_q)
		: colour_q;
	assign wr_mask    = BYTE_W'(1) << bitsel_q;

	// memory port control
	always_comb begin
		fb_re    = 1'b0;
		fb_raddr = '0;
		fb_we    = 1'b0;
		fb_waddr = addr_q;
		fb_wdata = wr_bit ? (fb_rdata_q | wr_mask) : (fb_rdata_q & ~wr_mask);
		gly_re   = 1'b0;
		gly_we   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				fb_we    = 1'b1;
				fb_waddr = fill_cnt_q;
				fb_wdata = FILL_BLACK;
			end
			ST_FILL: begin
				fb_we    = 1'b1;
				fb_waddr = fill_cnt_q;
				fb_wdata = fill_val_q;
			end
			ST_IDLE: begin
				if (accept && in_cmd == CMD_PIXEL && pix_on_screen) begin
					fb_re    = 1'b1;
					fb_raddr = fb_addr(in_pos_x, in_pos_y);
				end
				if (accept && in_cmd == CMD_READ_BYTE && in_addr_ok) begin
					fb_re    = 1'b1;
					fb_raddr = FA_W'(in_addr);
				end
				gly_we = accept && in_cmd == CMD_LOAD_GLYPH && in_gidx_ok;
			end
			ST_CH_RD: begin
				fb_re    = 1'b1;
				fb_raddr = fb_addr(ch_x, ch_y);
				gly_re   = col_q == '0;
			end
			ST_PIX_WR, ST_CH_WR: begin
				fb_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fb_we)
			fb_mem[fb_waddr] <= fb_wdata;
		if (fb_re)
			fb_rdata_q <= fb_mem[fb_raddr];
	end

	always_ff @(posedge clk) begin
		if (gly_we)
			gly_mem[GA_W'(in_gidx)] <= in_gbits;
		if (gly_re)
			gly_rdata_q <= gly_mem[GA_W'(gidx_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			fill_cnt_q    <= '0;
			fill_val_q    <= FILL_BLACK;
			font_width_q  <= FONT_WIDTH_RST;
			font_height_q <= FONT_HEIGHT_RST;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			invert_q      <= 1'b0;
			addr_q        <= '0;
			bitsel_q      <= '0;
			colour_q      <= 1'b0;
			code_q        <= '0;
			gidx_q        <= '0;
			col_q         <= '0;
			row_q         <= '0;
			gly_ok_q      <= 1'b0;
			m_valid_q     <= 1'b0;
			m_status_q    <= STAT_DONE;
			m_char_q      <= '0;
			m_byte_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_FONT_WIDTH:  font_width_q  <= cfg_data;
					REG_FONT_HEIGHT: font_height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					fill_cnt_q <= fill_cnt_q + 1'b1;
					if (fill_cnt_q == FA_LAST) begin
						fill_cnt_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				ST_FILL: begin
					if (fill_cnt_q != FA_LAST) begin
						fill_cnt_q <= fill_cnt_q + 1'b1;
					end else if (out_free) begin
						fill_cnt_q <= '0;
						m_valid_q  <= 1'b1;
						m_status_q <= STAT_DONE;
						m_char_q   <= '0;
						m_byte_q   <= '0;
						state_q    <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						m_valid_q  <= 1'b1;
						m_status_q <= STAT_DONE;
						m_char_q   <= '0;
						m_byte_q   <= '0;
						case (in_cmd)
							CMD_FILL: begin
								m_valid_q  <= 1'b0;
								fill_val_q <= in_colour ? FILL_WHITE : FILL_BLACK;
								state_q    <= ST_FILL;
							end
							CMD_PIXEL: begin
								if (pix_on_screen) begin
									m_valid_q <= 1'b0;
									addr_q    <= fb_addr(in_pos_x, in_pos_y);
									bitsel_q  <= in_pos_y[2:0];
									colour_q  <= in_colour ^ invert_q;
									state_q   <= ST_PIX_WR;
								end else begin
									m_status_q <= STAT_RANGE;
								end
							end
							CMD_CHAR: begin
								if (char_edge_bad) begin
									m_status_q <= STAT_RANGE;
								end else if (char_code_bad) begin
									m_status_q <= STAT_CODE;
								end else if (char_empty) begin
									m_char_q     <= in_char;
									cursor_col_q <= cursor_col_q + COORD_W'(font_width_q);
								end else begin
									m_valid_q <= 1'b0;
									code_q    <= in_char;
									colour_q  <= in_colour;
									gidx_q    <= gidx_base;
									col_q     <= '0;
									row_q     <= '0;
									state_q   <= ST_CH_RD;
								end
							end
							CMD_CURSOR: begin
								cursor_col_q <= in_pos_x;
								cursor_row_q <= in_pos_y;
							end
							CMD_INVERT: begin
								invert_q <= !invert_q;
							end
							CMD_LOAD_GLYPH: begin
								if (!in_gidx_ok)
									m_status_q <= STAT_RANGE;
							end
							CMD_READ_BYTE: begin
								if (in_addr_ok) begin
									m_valid_q <= 1'b0;
									state_q   <= ST_RD;
								end else begin
									m_status_q <= STAT_RANGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PIX_WR: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_status_q <= STAT_DONE;
						m_char_q   <= '0;
						m_byte_q   <= '0;
						state_q    <= ST_IDLE;
					end
				end
				ST_RD: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_status_q <= STAT_DONE;
						m_char_q   <= '0;
						m_byte_q   <= fb_rdata_q;
						state_q    <= ST_IDLE;
					end
				end
				ST_CH_RD: begin
					if (col_q == '0)
						gly_ok_q <= int'(gidx_q) < GLYPH_DEPTH;
					addr_q   <= fb_addr(ch_x, ch_y);
					bitsel_q <= ch_y[2:0];
					state_q  <= ST_CH_WR;
				end
				ST_CH_WR: begin
					if (!last_col) begin
						col_q   <= col_q + 1'b1;
						state_q <= ST_CH_RD;
					end else if (!last_row) begin
						col_q   <= '0;
						row_q   <= row_q + 1'b1;
						gidx_q  <= gidx_q + 1'b1;
						state_q <= ST_CH_RD;
					end else if (out_free) begin
						col_q        <= '0;
						row_q        <= '0;
						cursor_col_q <= cursor_col_q + COORD_W'(font_width_q);
						m_valid_q    <= 1'b1;
						m_status_q   <= STAT_DONE;
						m_char_q     <= code_q;
						m_byte_q     <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// frame port is single ported per cycle
	a_fb_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(fb_we && fb_re))
		else $error("frame memory read and write in the same cycle");

	a_fb_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		fb_we |-> (int'(fb_waddr) < FRAME_BYTES))
		else $error("frame write outside the buffer");

	a_blit_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CH_RD || state_q == ST_CH_WR)
		|-> (col_q < font_width_q && row_q < font_height_q))
		else $error("blit counters beyond glyph size");

	a_cursor_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cursor_col_q) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_CH_WR))
		else $error("cursor moved outside a command");

endmodule
